// ===== design/crpe_pkg.sv =====
// crpe_pkg: shared types and constants of the Catmull-Rom point evaluator
// used by crpe_ctrl, crpe_axis and catmull_rom_point_eval_2d_top
`timescale 1ns / 1ps
`default_nettype none
package crpe_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 12;
   localparam int COORD_FRAC = 4;
   localparam int CLAMP_SPAN = 5 << COORD_FRAC;
   localparam int NUM_STAGES = 6;

   // datapath widths
   localparam int W_P  = COORD_BITS + 2;
   localparam int W_A  = W_P + 1;
   localparam int W_C  = W_P + 4;
   localparam int W_M1 = W_C + FRAC_BITS + 1;
   localparam int W_M2 = W_M1 + FRAC_BITS + 1;
   localparam int W_M3 = W_M2 + FRAC_BITS + 1;
   localparam int R_SHIFT = 3 * FRAC_BITS + 1;
   localparam int W_R  = W_M3 - R_SHIFT;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_before;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] x_after;
      logic signed [COORD_BITS-1:0] y_before;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] y_end;
      logic signed [COORD_BITS-1:0] y_after;
      logic        [FRAC_BITS-1:0]  frac_t;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_out;
      logic signed [COORD_BITS-1:0] y_out;
      logic                         saturated;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] vld;
   } ctrl_type;

endpackage
`default_nettype wire

// ===== design/crpe_ctrl.sv =====
// crpe_ctrl: per-stage valid bits and ready chain of the evaluator pipeline
// depends on crpe_pkg
`timescale 1ns / 1ps
`default_nettype none
module crpe_ctrl
   import crpe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire logic     rsp_ready,
   output ctrl_type      ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready[0];
   assign ctrl.en   = ready;
   assign ctrl.vld  = valid_ff;

   // back-pressure reaches the input only when every stage is occupied
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input blocked with a bubble in the pipeline");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-1] && !rsp_ready |=> valid_ff[NUM_STAGES-1])
      else $error("stalled result dropped");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted request not in first stage");

endmodule
`default_nettype wire

// ===== design/crpe_axis.sv =====
// crpe_axis: six-stage datapath for one axis: clamp, basis sums, three
// multiply-accumulate steps in Horner form, round and saturate; uses crpe_pkg
`timescale 1ns / 1ps
`default_nettype none
module crpe_axis
   import crpe_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic [NUM_STAGES-1:0]        en,
   input  wire logic signed [COORD_BITS-1:0] p0,
   input  wire logic signed [COORD_BITS-1:0] p1,
   input  wire logic signed [COORD_BITS-1:0] p2,
   input  wire logic signed [COORD_BITS-1:0] p3,
   input  wire logic        [FRAC_BITS-1:0]  frac_t,
   output logic signed [COORD_BITS-1:0]      coord_out,
   output logic                              clip_out
);

   localparam logic signed [W_P-1:0] SPAN = W_P'(CLAMP_SPAN);

   // stage 0: clamped control points
   logic signed [W_P-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [W_P-1:0] p0_in, p3_in;
   logic signed [W_P-1:0] p0e, p1e, p2e, p3e;
   logic [FRAC_BITS-1:0]  t0_ff, t1_ff, t2_ff, t3_ff;

   // stage 1: basis coefficients
   logic signed [W_A-1:0] a_ff, b_ff, a_in, b_in;
   logic signed [W_C-1:0] c_ff, d_ff, c_in, d_in;

   // stages 2 to 4: Horner accumulation
   logic signed [W_A-1:0]  a2_ff, b2_ff, a3_ff;
   logic signed [W_M1-1:0] m1_ff, m1_in;
   logic signed [W_M2-1:0] m2_ff, m2_in;
   logic signed [W_M3-1:0] m3_ff, m3_in;

   // stage 5: rounded and saturated result
   logic signed [W_R-1:0]        r_val;
   logic                         clip_in;
   logic signed [COORD_BITS-1:0] coord_in;

   always_comb begin
      p0e = W_P'(p0);
      p1e = W_P'(p1);
      p2e = W_P'(p2);
      p3e = W_P'(p3);
      p0_in = p0e;
      if (p0e < p1e - SPAN) begin
         p0_in = p1e - SPAN;
      end else if (p0e > p1e + SPAN) begin
         p0_in = p1e + SPAN;
      end
      p3_in = p3e;
      if (p3e < p2e - SPAN) begin
         p3_in = p2e - SPAN;
      end else if (p3e > p2e + SPAN) begin
         p3_in = p2e + SPAN;
      end
   end

   // a carries the rounding half: 2*p1 + 1
   always_comb begin
      a_in = {p1_ff, 1'b1};
      b_in = W_A'(p2_ff) - W_A'(p0_ff);
      c_in = (W_C'(p0_ff) <<< 1) - (W_C'(p1_ff) <<< 2) - W_C'(p1_ff)
           + (W_C'(p2_ff) <<< 2) - W_C'(p3_ff);
      d_in = W_C'(p1_ff) + (W_C'(p1_ff) <<< 1) - W_C'(p2_ff) - (W_C'(p2_ff) <<< 1)
           + W_C'(p3_ff) - W_C'(p0_ff);
   end

   always_comb begin
      m1_in = W_M1'(d_ff) * W_M1'($signed({1'b0, t1_ff}))
            + (W_M1'(c_ff) <<< FRAC_BITS);
      m2_in = W_M2'(m1_ff) * W_M2'($signed({1'b0, t2_ff}))
            + (W_M2'(b2_ff) <<< (2 * FRAC_BITS));
      m3_in = W_M3'(m2_ff) * W_M3'($signed({1'b0, t3_ff}))
            + (W_M3'(a3_ff) <<< (3 * FRAC_BITS));
   end

   always_comb begin
      r_val   = W_R'(m3_ff >>> R_SHIFT);
      clip_in = !((&r_val[W_R-1:COORD_BITS-1]) || !(|r_val[W_R-1:COORD_BITS-1]));
      if (clip_in) begin
         coord_in = r_val[W_R-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
         coord_in = r_val[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p0_ff <= p0_in;
         p1_ff <= p1e;
         p2_ff <= p2e;
         p3_ff <= p3_in;
         t0_ff <= frac_t;
      end
      if (en[1]) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         c_ff  <= c_in;
         d_ff  <= d_in;
         t1_ff <= t0_ff;
      end
      if (en[2]) begin
         m1_ff <= m1_in;
         a2_ff <= a_ff;
         b2_ff <= b_ff;
         t2_ff <= t1_ff;
      end
      if (en[3]) begin
         m2_ff <= m2_in;
         a3_ff <= a2_ff;
         t3_ff <= t2_ff;
      end
      if (en[4]) begin
         m3_ff <= m3_in;
      end
      if (en[5]) begin
         coord_out <= coord_in;
         clip_out  <= clip_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/catmull_rom_point_eval_2d_top.sv =====
// pipeline: six stages; rsp_valid is the valid bit of the last stage
// throughput: one request per cycle while rsp_ready is high; each stage holds
// one request and a stall only holds full stages, so bubbles close up
// the deepest stage is a 48 x 13 bit multiply-accumulate per axis
// reset clears the stage valid bits; datapath registers are not reset
// depends on crpe_pkg, crpe_ctrl, crpe_axis
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_point_eval_2d_top
   import crpe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   ctrl_type                     ctrl;
   logic signed [COORD_BITS-1:0] x_val, y_val;
   logic                         x_clip, y_clip;

   crpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   crpe_axis u_axis_x (
      .clock     (clock),
      .en        (ctrl.en),
      .p0        (req_data.x_before),
      .p1        (req_data.x_start),
      .p2        (req_data.x_end),
      .p3        (req_data.x_after),
      .frac_t    (req_data.frac_t),
      .coord_out (x_val),
      .clip_out  (x_clip)
   );

   crpe_axis u_axis_y (
      .clock     (clock),
      .en        (ctrl.en),
      .p0        (req_data.y_before),
      .p1        (req_data.y_start),
      .p2        (req_data.y_end),
      .p3        (req_data.y_after),
      .frac_t    (req_data.frac_t),
      .coord_out (y_val),
      .clip_out  (y_clip)
   );

   assign rsp_valid          = ctrl.vld[NUM_STAGES-1];
   assign rsp_data.x_out     = x_val;
   assign rsp_data.y_out     = y_val;
   assign rsp_data.saturated = x_clip | y_clip;

endmodule
`default_nettype wire

// ===== tb/catmull_rom_point_eval_2d_top_test.sv =====
// catmull_rom_point_eval_2d_top_test: checks every response of the 2-d Catmull-Rom
// point evaluator against a built-in fixed-point predictor, over directed and random
// requests and four handshake idle phases; depends on crpe_pkg and the top module
`timescale 1ns / 1ps
module catmull_rom_point_eval_2d_top_test;
   import crpe_pkg::*;

   localparam int     COORD_HI  = (1 << (COORD_BITS - 1)) - 1;
   localparam int     COORD_LO  = -(1 << (COORD_BITS - 1));
   localparam int     T_MAX     = (1 << FRAC_BITS) - 1;
   localparam int     PHASE_REQS = 184;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type queued_queries[$];
   rsp_type expected_points[$];
   logic    req_fire  = 1'b0;
   int      idle_send = 0;
   int      idle_recv = 0;
   int      issued    = 0;
   int      checked   = 0;
   int      clipped   = 0;
   int      failures  = 0;

   catmull_rom_point_eval_2d_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one axis: clamp outer points, cubic weights via horner, halve with rounding, saturate
   function automatic logic signed [COORD_BITS-1:0] eval_axis(
      input longint p0_in, input longint p1, input longint p2, input longint p3_in,
      input longint t, output bit clip);
      longint p0, p3, a, b, c, d, acc, r;
      p0 = p0_in;
      p3 = p3_in;
      if (p0 < p1 - CLAMP_SPAN) p0 = p1 - CLAMP_SPAN;
      if (p0 > p1 + CLAMP_SPAN) p0 = p1 + CLAMP_SPAN;
      if (p3 < p2 - CLAMP_SPAN) p3 = p2 - CLAMP_SPAN;
      if (p3 > p2 + CLAMP_SPAN) p3 = p2 + CLAMP_SPAN;
      a = 2 * p1;
      b = p2 - p0;
      c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      d = -p0 + 3 * p1 - 3 * p2 + p3;
      acc = d;
      acc = acc * t + (c <<< FRAC_BITS);
      acc = acc * t + (b <<< (2 * FRAC_BITS));
      acc = acc * t + (a <<< (3 * FRAC_BITS)) + (longint'(1) <<< (3 * FRAC_BITS));
      r = acc >>> (3 * FRAC_BITS + 1);
      clip = 1'b0;
      if (r > COORD_HI) begin
         clip = 1'b1;
         r = COORD_HI;
      end
      if (r < COORD_LO) begin
         clip = 1'b1;
         r = COORD_LO;
      end
      return r[COORD_BITS-1:0];
   endfunction

   function automatic rsp_type eval_point(req_type q);
      rsp_type p;
      bit      cx, cy;
      p.x_out = eval_axis(longint'(q.x_before), longint'(q.x_start), longint'(q.x_end),
                          longint'(q.x_after), longint'(q.frac_t), cx);
      p.y_out = eval_axis(longint'(q.y_before), longint'(q.y_start), longint'(q.y_end),
                          longint'(q.y_after), longint'(q.frac_t), cy);
      p.saturated = cx | cy;
      return p;
   endfunction

   function automatic req_type mk_req(int xb, int xs, int xe, int xa,
                                      int yb, int ys, int ye, int ya, int t);
      req_type q;
      q.x_before = COORD_BITS'(xb);
      q.x_start  = COORD_BITS'(xs);
      q.x_end    = COORD_BITS'(xe);
      q.x_after  = COORD_BITS'(xa);
      q.y_before = COORD_BITS'(yb);
      q.y_start  = COORD_BITS'(ys);
      q.y_end    = COORD_BITS'(ye);
      q.y_after  = COORD_BITS'(ya);
      q.frac_t   = FRAC_BITS'(t);
      return q;
   endfunction

   function automatic void enqueue_req(req_type q);
      queued_queries = {queued_queries, q};
   endfunction

   function automatic int any_coord();
      logic signed [COORD_BITS-1:0] w;
      w = COORD_BITS'($urandom);
      return int'(w);
   endfunction

   function automatic int near_coord(int base, int spread);
      int v;
      v = base + int'($urandom_range(2 * spread)) - spread;
      if (v > COORD_HI) v = COORD_HI;
      if (v < COORD_LO) v = COORD_LO;
      return v;
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(4))
         0: return COORD_HI;
         1: return COORD_LO;
         2: return 0;
         3: return -1;
         default: return any_coord();
      endcase
   endfunction

   // mostly local point clusters so the clamp goes both ways, plus edge and wild cases
   function automatic void random_axis(output int pb, output int ps, output int pe,
                                       output int pa);
      int kind, base;
      kind = $urandom_range(99);
      if (kind < 25) begin
         pb = any_coord();
         ps = any_coord();
         pe = any_coord();
         pa = any_coord();
      end else if (kind < 65) begin
         ps = any_coord();
         pe = near_coord(ps, 160);
         pb = near_coord(ps, 140);
         pa = near_coord(pe, 140);
      end else if (kind < 85) begin
         base = $urandom_range(1) ? COORD_HI : COORD_LO;
         ps = near_coord(base, 60);
         pe = near_coord(ps, 60);
         pb = near_coord(ps, 120);
         pa = near_coord(pe, 120);
      end else begin
         pb = extreme_coord();
         ps = extreme_coord();
         pe = extreme_coord();
         pa = extreme_coord();
      end
   endfunction

   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fire) begin
            if (queued_queries.size() != 0 && $urandom_range(99) >= idle_send) begin
               req_valid <= 1'b1;
               req_data  <= queued_queries.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_recv);
      end
   end

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) expected_points = {expected_points, eval_point(req_data)};
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected response x_out %0d y_out %0d", rsp_data.x_out,
                      rsp_data.y_out);
               failures++;
            end else begin
               want = expected_points.pop_front();
               checked++;
               if (want.saturated) clipped++;
               if (rsp_data.x_out !== want.x_out) begin
                  $error("x_out: expected %0d, got %0d", want.x_out, rsp_data.x_out);
                  failures++;
               end
               if (rsp_data.y_out !== want.y_out) begin
                  $error("y_out: expected %0d, got %0d", want.y_out, rsp_data.y_out);
                  failures++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d", want.saturated,
                         rsp_data.saturated);
                  failures++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      int xb, xs, xe, xa, yb, ys, ye, ya, t;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_send = 0;  idle_recv = 0;  end
            1: begin idle_send = 52; idle_recv = 0;  end
            2: begin idle_send = 0;  idle_recv = 52; end
            default: begin idle_send = 22; idle_recv = 22; end
         endcase
         if (phase == 0) begin
            enqueue_req(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
            enqueue_req(mk_req(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                               COORD_HI, COORD_HI, COORD_HI, COORD_HI, T_MAX));
            enqueue_req(mk_req(COORD_LO, COORD_LO, COORD_LO, COORD_LO,
                               COORD_LO, COORD_LO, COORD_LO, COORD_LO, T_MAX));
            // overshoot past the top and bottom of the range
            enqueue_req(mk_req(COORD_HI - 80, COORD_HI, COORD_HI, COORD_HI - 80,
                               COORD_LO + 80, COORD_LO, COORD_LO, COORD_LO + 80,
                               2048));
            enqueue_req(mk_req(COORD_HI - 40, COORD_HI, COORD_HI - 10,
                               COORD_HI - 200, COORD_LO + 300, COORD_LO,
                               COORD_LO + 5, COORD_LO + 30, 1024));
            // far outer points, clamp at full precision near the edges
            enqueue_req(mk_req(COORD_LO, COORD_HI, COORD_HI, COORD_LO,
                               COORD_HI, COORD_LO, COORD_LO, COORD_HI, 1));
            enqueue_req(mk_req(COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                               COORD_HI, COORD_LO, COORD_HI, COORD_LO, 2048));
            enqueue_req(mk_req(-5000, 100, 200, 9000, 7000, -300, -250, -9000,
                               T_MAX));
            // outer points just inside and just outside the clamp window
            enqueue_req(mk_req(20, 100, 180, 260, -20, -100, -180, -261, 3000));
            enqueue_req(mk_req(19, 100, 180, 261, -21, -100, -180, -260, 777));
            // t = 0 gives the start point, t near one approaches the end point
            enqueue_req(mk_req(1111, 1234, -876, 555, -4321, -3333, 2222, 99, 0));
            enqueue_req(mk_req(1111, 1234, -876, 555, -4321, -3333, 2222, 99,
                               T_MAX));
            // small odd values exercise rounding of halves
            enqueue_req(mk_req(0, 0, 1, 1, -1, -1, -2, -2, 2048));
            enqueue_req(mk_req(-1, -1, -1, -1, 1, 0, -1, 0, 1));
            enqueue_req(mk_req(3, 1, 0, -3, -3, -1, 0, 3, 4094));
            enqueue_req(mk_req(32, 16, 16, 32, -32, -16, -16, -32, 2048));
            issued += 16;
         end
         for (int k = 0; k < PHASE_REQS; k++) begin
            random_axis(xb, xs, xe, xa);
            random_axis(yb, ys, ye, ya);
            if ($urandom_range(99) < 75) begin
               t = $urandom_range(T_MAX);
            end else begin
               case ($urandom_range(3))
                  0: t = 0;
                  1: t = 1;
                  2: t = 2048;
                  default: t = T_MAX;
               endcase
            end
            enqueue_req(mk_req(xb, xs, xe, xa, yb, ys, ye, ya, t));
            issued++;
         end
         do @(negedge clock); while (checked < issued);
         @(posedge clock);
      end
      repeat (20) @(negedge clock);
      if (expected_points.size() != 0) begin
         $error("%0d responses never arrived", expected_points.size());
         failures++;
      end
      $display("%0d requests through four idle/stall phases, %0d responses checked",
               issued, checked);
      $display("%0d responses saturated on at least one axis", clipped);
      if (failures == 0)
         $display("catmull_rom_point_eval_2d_top regression: pass");
      else
         $display("catmull_rom_point_eval_2d_top regression: fail");
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("catmull_rom_point_eval_2d_top regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/crpe_pkg.sv
design/crpe_ctrl.sv
design/crpe_axis.sv
design/catmull_rom_point_eval_2d_top.sv
tb/catmull_rom_point_eval_2d_top_test.sv
